### hdl/rfdt_pkg.sv
// Package for the ring fill drift trim loop: widths, reset values, codes and state type.
package rfdt_pkg;

	// Field widths fixed by the interface.
	localparam int FILL_W      = 16;
	localparam int WANT_W      = 12;
	localparam int ACT_W       = 2;
	localparam int TRIM_W      = 25;
	localparam int GAIN_W      = 24;
	localparam int COEFF_W     = 16;
	localparam int CNT8_W      = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;

	// Fractional bits of the trim and of the relative error.
	localparam int TRIM_FRAC   = 24;

	// Derived datapath widths.
	localparam int SM_W        = FILL_W + 16;                  // smoothed fill, Q16.16
	localparam int DIV_W       = SM_W + TRIM_FRAC - 16 + 1;    // dividend and quotient
	localparam int EMAG_W      = TRIM_FRAC + 8;                // saturated error magnitude
	localparam int MUL_A_W     = (SM_W > EMAG_W) ? SM_W : EMAG_W;
	localparam int PROD_W      = MUL_A_W + GAIN_W;
	localparam int TMAG_W      = PROD_W - TRIM_FRAC + 1;
	localparam int DCNT_W      = $clog2(DIV_W);

	localparam logic [EMAG_W-1:0] ERR_LIMIT = EMAG_W'(255) << TRIM_FRAC;

	// Register reset values.
	localparam logic [FILL_W-1:0]  TARGET_RST   = FILL_W'(1440);
	localparam logic [FILL_W-1:0]  ARM_RST      = FILL_W'(480);
	localparam logic [CNT8_W-1:0]  MAXP_RST     = CNT8_W'(100);
	localparam logic [COEFF_W-1:0] COEFF_RST    = COEFF_W'(98);
	localparam logic [GAIN_W-1:0]  GAIN_RST     = GAIN_W'(16777);
	localparam logic [GAIN_W-1:0]  MAX_TRIM_RST = GAIN_W'(33554);

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ARM      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAXP     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEFF    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TRIM = 3'd5;

	// Result actions.
	localparam logic [ACT_W-1:0] ACT_SKIP  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_PRIME = 2'd1;
	localparam logic [ACT_W-1:0] ACT_PLAY  = 2'd2;

	// Sequencer states.
	typedef enum logic [10:0] {
		ST_IDLE   = 11'b000_0000_0001,
		ST_DECIDE = 11'b000_0000_0010,
		ST_SMUL   = 11'b000_0000_0100,
		ST_UPDATE = 11'b000_0000_1000,
		ST_ERR    = 11'b000_0001_0000,
		ST_LOAD   = 11'b000_0010_0000,
		ST_DIV    = 11'b000_0100_0000,
		ST_SAT    = 11'b000_1000_0000,
		ST_GMUL   = 11'b001_0000_0000,
		ST_ROUND  = 11'b010_0000_0000,
		ST_EMIT   = 11'b100_0000_0000
	} state_t;

endpackage

### hdl/ring_fill_drift_trim_loop_core.sv
// Top level of the ring fill drift trim loop: sequencer, shared multiplier and serial divider.
//
// Usage: each beat on the slave stream is one render wake. s_tdata carries the ring
// fill and the frames the device wants; the block answers exactly one beat on the
// master stream per wake. m_tuser carries the action (skip, priming silence or play)
// and m_tdata carries the trim offset and the low and high fill marks.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes one
// register per beat and is always ready; it is meant to be used while the block is idle.
//
// Flow: a wake is taken only while the sequencer is idle. A skip or priming wake
// passes the decide step and then the emit step. A play wake runs through one shared
// multiplier twice (smoothing, then gain) and a restoring divider that resolves one
// quotient bit per cycle over 41 bits. The block takes its next wake in the cycle after
// the answer is loaded into the output register, and one wake can be in work while the
// previous answer waits.
//
// Reset: arst_n clears the sequencer, the output valid, the priming state and the marks,
// loads the register reset values and sets the smoothed fill to the target reset value.
// When the receiver stalls, the finished answer holds in the output register and a new
// answer waits in the emit step until the register frees up.
module ring_fill_drift_trim_loop_core (
	input  logic                              clk,
	input  logic                              arst_n,
	// Slave stream. s_tdata: fill_frames [15:0], frames_wanted [27:16], zero [31:28].
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [31:0]                       s_tdata,
	// Master stream. m_tdata: trim_offset [24:0], low_mark [40:25], high_mark [56:41],
	// zero [63:57]. m_tuser: action [1:0].
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [63:0]                       m_tdata,
	output logic [rfdt_pkg::ACT_W-1:0]        m_tuser,
	// Configuration write channel.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rfdt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rfdt_pkg::CFG_DATA_W-1:0]   cfg_data
);

	// Configuration registers.
	logic [rfdt_pkg::FILL_W-1:0]  target_q;
	logic [rfdt_pkg::FILL_W-1:0]  arm_q;
	logic [rfdt_pkg::CNT8_W-1:0]  maxp_q;
	logic [rfdt_pkg::COEFF_W-1:0] coeff_q;
	logic [rfdt_pkg::GAIN_W-1:0]  gain_q;
	logic [rfdt_pkg::GAIN_W-1:0]  max_trim_q;

	// Loop state.
	logic                         primed_q;
	logic [rfdt_pkg::CNT8_W-1:0]  prime_cnt_q;
	logic [rfdt_pkg::SM_W-1:0]    smoothed_q;
	logic                         low_armed_q;
	logic [rfdt_pkg::FILL_W-1:0]  fill_min_q;
	logic [rfdt_pkg::FILL_W-1:0]  fill_max_q;
	logic [rfdt_pkg::TRIM_W-1:0]  last_trim_q;

	// Work registers of the current wake.
	rfdt_pkg::state_t             state_q;
	logic [rfdt_pkg::FILL_W-1:0]  fill_q;
	logic [rfdt_pkg::WANT_W-1:0]  wanted_q;
	logic [rfdt_pkg::ACT_W-1:0]   action_q;
	logic [rfdt_pkg::SM_W-1:0]    acc_q;
	logic                         sm_neg_q;
	logic                         err_neg_q;
	logic [rfdt_pkg::FILL_W-1:0]  divisor_q;
	logic [rfdt_pkg::FILL_W-1:0]  rem_q;
	logic [rfdt_pkg::DIV_W-1:0]   dvd_q;
	logic [rfdt_pkg::DCNT_W-1:0]  div_cnt_q;
	logic [rfdt_pkg::EMAG_W-1:0]  emag_q;
	logic [rfdt_pkg::PROD_W-1:0]  prod_q;
	logic [rfdt_pkg::TMAG_W-1:0]  tmag_q;

	// Output register.
	logic                         m_tvalid_q;
	logic [63:0]                  m_tdata_q;
	logic [rfdt_pkg::ACT_W-1:0]   m_tuser_q;

	// Shared multiplier operands and product.
	logic [rfdt_pkg::MUL_A_W-1:0] mul_a;
	logic [rfdt_pkg::GAIN_W-1:0]  mul_b;
	logic [rfdt_pkg::PROD_W-1:0]  mul_p;

	// Combinational helpers.
	logic [rfdt_pkg::SM_W-1:0]    raw_fill;
	logic [rfdt_pkg::SM_W-1:0]    target_q16;
	logic [rfdt_pkg::SM_W:0]      sm_round;
	logic [rfdt_pkg::SM_W-1:0]    sm_step;
	logic                         arm_next;
	logic [rfdt_pkg::FILL_W:0]    rem_shift;
	logic                         rem_ge;
	logic [rfdt_pkg::PROD_W:0]    gain_round;
	logic [rfdt_pkg::TRIM_W-1:0]  tmag_clamped;
	logic                         out_free;
	logic                         emit_fire;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == rfdt_pkg::ST_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;
	assign out_free  = !m_tvalid_q || m_tready;

	// The answer moves into the output register in this cycle.
	assign emit_fire = (state_q == rfdt_pkg::ST_EMIT) && (action_q != rfdt_pkg::ACT_PLAY)
		&& out_free;

	assign raw_fill   = {fill_q, 16'd0};
	assign target_q16 = {target_q, 16'd0};

	// The multiplier serves the smoothing step with the fill difference and the
	// coefficient, and the gain step with the saturated error and the gain.
	always_comb begin
		if (state_q == rfdt_pkg::ST_SMUL) begin
			mul_a = rfdt_pkg::MUL_A_W'(acc_q);
			mul_b = rfdt_pkg::GAIN_W'(coeff_q);
		end else begin
			mul_a = rfdt_pkg::MUL_A_W'(emag_q);
			mul_b = gain_q;
		end
	end
	assign mul_p = rfdt_pkg::PROD_W'(mul_a) * rfdt_pkg::PROD_W'(mul_b);

	// Rounded smoothing step, ties away from zero on the magnitude.
	assign sm_round = (rfdt_pkg::SM_W+1)'(prod_q[rfdt_pkg::SM_W+15:16])
		+ (rfdt_pkg::SM_W+1)'(prod_q[15]);
	assign sm_step  = sm_round[rfdt_pkg::SM_W-1:0];

	assign arm_next = low_armed_q || (fill_q >= arm_q);

	// One restoring divider step.
	assign rem_shift = {rem_q, dvd_q[rfdt_pkg::DIV_W-1]};
	assign rem_ge    = rem_shift >= {1'b0, divisor_q};

	// Rounded trim magnitude before the clamp.
	assign gain_round = {1'b0, prod_q}
		+ ((rfdt_pkg::PROD_W+1)'(1) << (rfdt_pkg::TRIM_FRAC - 1));

	assign tmag_clamped = (tmag_q > rfdt_pkg::TMAG_W'(max_trim_q))
		? rfdt_pkg::TRIM_W'(max_trim_q) : rfdt_pkg::TRIM_W'(tmag_q);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q   <= rfdt_pkg::TARGET_RST;
			arm_q      <= rfdt_pkg::ARM_RST;
			maxp_q     <= rfdt_pkg::MAXP_RST;
			coeff_q    <= rfdt_pkg::COEFF_RST;
			gain_q     <= rfdt_pkg::GAIN_RST;
			max_trim_q <= rfdt_pkg::MAX_TRIM_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rfdt_pkg::REG_TARGET:   target_q   <= cfg_data[rfdt_pkg::FILL_W-1:0];
				rfdt_pkg::REG_ARM:      arm_q      <= cfg_data[rfdt_pkg::FILL_W-1:0];
				rfdt_pkg::REG_MAXP:     maxp_q     <= cfg_data[rfdt_pkg::CNT8_W-1:0];
				rfdt_pkg::REG_COEFF:    coeff_q    <= cfg_data[rfdt_pkg::COEFF_W-1:0];
				rfdt_pkg::REG_GAIN:     gain_q     <= cfg_data[rfdt_pkg::GAIN_W-1:0];
				rfdt_pkg::REG_MAX_TRIM: max_trim_q <= cfg_data[rfdt_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and loop state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rfdt_pkg::ST_IDLE;
			primed_q    <= 1'b0;
			prime_cnt_q <= '0;
			smoothed_q  <= rfdt_pkg::SM_W'(rfdt_pkg::TARGET_RST) << 16;
			low_armed_q <= 1'b0;
			fill_min_q  <= '1;
			fill_max_q  <= '0;
			last_trim_q <= '0;
			div_cnt_q   <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			// A new answer may load in the same cycle the receiver takes the old one.
			if (emit_fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				rfdt_pkg::ST_IDLE: begin
					if (s_tvalid) begin
						fill_q   <= s_tdata[rfdt_pkg::FILL_W-1:0];
						wanted_q <= s_tdata[rfdt_pkg::FILL_W +: rfdt_pkg::WANT_W];
						state_q  <= rfdt_pkg::ST_DECIDE;
					end
				end
				rfdt_pkg::ST_DECIDE: begin
					// A wake that wants nothing is skipped; before priming completes,
					// a low fill answers silence until the wake limit runs out.
					if (wanted_q == '0) begin
						action_q <= rfdt_pkg::ACT_SKIP;
						state_q  <= rfdt_pkg::ST_EMIT;
					end else if (!primed_q && fill_q < target_q && prime_cnt_q < maxp_q) begin
						prime_cnt_q <= prime_cnt_q + 1'b1;
						action_q    <= rfdt_pkg::ACT_PRIME;
						state_q     <= rfdt_pkg::ST_EMIT;
					end else begin
						primed_q <= 1'b1;
						action_q <= rfdt_pkg::ACT_PLAY;
						sm_neg_q <= raw_fill < smoothed_q;
						acc_q    <= (raw_fill < smoothed_q) ? smoothed_q - raw_fill
							: raw_fill - smoothed_q;
						state_q  <= rfdt_pkg::ST_SMUL;
					end
				end
				rfdt_pkg::ST_SMUL: begin
					prod_q  <= mul_p;
					state_q <= rfdt_pkg::ST_UPDATE;
				end
				rfdt_pkg::ST_UPDATE: begin
					smoothed_q  <= sm_neg_q ? smoothed_q - sm_step : smoothed_q + sm_step;
					low_armed_q <= arm_next;
					if (arm_next && fill_q < fill_min_q) begin
						fill_min_q <= fill_q;
					end
					if (fill_q > fill_max_q) begin
						fill_max_q <= fill_q;
					end
					state_q <= rfdt_pkg::ST_ERR;
				end
				rfdt_pkg::ST_ERR: begin
					err_neg_q <= smoothed_q < target_q16;
					acc_q     <= (smoothed_q < target_q16) ? target_q16 - smoothed_q
						: smoothed_q - target_q16;
					// A zero target divides as one.
					divisor_q <= (target_q == '0) ? rfdt_pkg::FILL_W'(1) : target_q;
					state_q   <= rfdt_pkg::ST_LOAD;
				end
				rfdt_pkg::ST_LOAD: begin
					dvd_q     <= (rfdt_pkg::DIV_W'(acc_q) << (rfdt_pkg::TRIM_FRAC - 16))
						+ rfdt_pkg::DIV_W'(divisor_q[rfdt_pkg::FILL_W-1:1]);
					rem_q     <= '0;
					div_cnt_q <= rfdt_pkg::DCNT_W'(rfdt_pkg::DIV_W - 1);
					state_q   <= rfdt_pkg::ST_DIV;
				end
				rfdt_pkg::ST_DIV: begin
					rem_q <= rem_ge ? rfdt_pkg::FILL_W'(rem_shift - {1'b0, divisor_q})
						: rem_shift[rfdt_pkg::FILL_W-1:0];
					dvd_q <= {dvd_q[rfdt_pkg::DIV_W-2:0], rem_ge};
					if (div_cnt_q == '0) begin
						state_q <= rfdt_pkg::ST_SAT;
					end else begin
						div_cnt_q <= div_cnt_q - 1'b1;
					end
				end
				rfdt_pkg::ST_SAT: begin
					emag_q  <= (dvd_q > rfdt_pkg::DIV_W'(rfdt_pkg::ERR_LIMIT))
						? rfdt_pkg::ERR_LIMIT : dvd_q[rfdt_pkg::EMAG_W-1:0];
					state_q <= rfdt_pkg::ST_GMUL;
				end
				rfdt_pkg::ST_GMUL: begin
					prod_q  <= mul_p;
					state_q <= rfdt_pkg::ST_ROUND;
				end
				rfdt_pkg::ST_ROUND: begin
					tmag_q  <= gain_round[rfdt_pkg::PROD_W:rfdt_pkg::TRIM_FRAC];
					state_q <= rfdt_pkg::ST_EMIT;
				end
				rfdt_pkg::ST_EMIT: begin
					// A play wake lands its clamped trim now; the trim opposes the error.
					if (action_q == rfdt_pkg::ACT_PLAY) begin
						last_trim_q <= err_neg_q ? tmag_clamped : -tmag_clamped;
						action_q    <= rfdt_pkg::ACT_SKIP;
					end else if (out_free) begin
						state_q    <= rfdt_pkg::ST_IDLE;
					end
				end
				default: state_q <= rfdt_pkg::ST_IDLE;
			endcase
		end
	end

	// The answer beat is packed from the settled state. The play path clears its own
	// action code above so the emit step only once pulls the trim in.
	logic [rfdt_pkg::ACT_W-1:0] emit_action_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_action_q <= rfdt_pkg::ACT_SKIP;
		end else if (state_q == rfdt_pkg::ST_DECIDE) begin
			if (wanted_q == '0) begin
				emit_action_q <= rfdt_pkg::ACT_SKIP;
			end else if (!primed_q && fill_q < target_q && prime_cnt_q < maxp_q) begin
				emit_action_q <= rfdt_pkg::ACT_PRIME;
			end else begin
				emit_action_q <= rfdt_pkg::ACT_PLAY;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			m_tuser_q <= emit_action_q;
			m_tdata_q <= {7'd0, fill_max_q, fill_min_q, last_trim_q};
		end
	end

	// A beat taken in idle closes the slave side at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("slave stream stayed ready after taking a wake");

	// Priming never undoes itself.
	assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(primed_q))
		else $error("primed flag cleared outside reset");

	// A play answer can only leave once the loop is primed.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tuser_q == rfdt_pkg::ACT_PLAY) |-> primed_q)
		else $error("play answer without priming");

	// Once a low mark is recorded it cannot exceed the high mark.
	assert property (@(posedge clk) disable iff (!arst_n)
		(fill_min_q != '1) |-> (fill_min_q <= fill_max_q))
		else $error("low mark above high mark");

	// After the load step the divider count starts at one less than its bit count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rfdt_pkg::ST_LOAD) |=> (div_cnt_q == rfdt_pkg::DCNT_W'(rfdt_pkg::DIV_W - 1)))
		else $error("divider count not loaded");

endmodule
